>>> rtl/core/epl_pkg.sv
// ----------------------------------------------------------------------------
// Euclidean path length: shared types and constants
// Item layouts, controller state encoding and the command and status bundles
// that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package epl_pkg;

  // Fixed widths of the item fields.
  localparam int unsigned InCoordW = 16;
  localparam int unsigned LengthW  = 40;
  localparam int unsigned CountW   = 16;

  localparam logic [LengthW-1:0] LengthMax = '1;
  localparam logic [CountW-1:0]  CountMax  = '1;

  // One point of the path.
  typedef struct packed {
    logic signed [InCoordW-1:0] point_x;
    logic signed [InCoordW-1:0] point_y;
    logic                       is_last;
  } point_t;

  // The result of one complete path.
  typedef struct packed {
    logic [LengthW-1:0] path_length;
    logic [CountW-1:0]  segment_count;
  } result_t;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQUARE,
    ST_LOAD,
    ST_ROOT,
    ST_ACC,
    ST_EMIT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic diff;
    logic square;
    logic load;
    logic step;
    logic acc;
    logic emit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic have_prev;
    logic last;
    logic in_last;
    logic root_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

`default_nettype wire

>>> rtl/core/epl_datapath.sv
// ----------------------------------------------------------------------------
// Euclidean path length: datapath
// Holds the previous point, the running length and count, the squaring
// stage, a restoring bit-pair square root and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module epl_datapath
  import epl_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ctrl_cmd_t cmd_i,
  output ctrl_sts_t      sts_o,
  input  wire point_t    in_item_i,
  input  wire logic      out_stall_i,
  output logic           out_valid_o,
  output result_t        out_item_o
);

  localparam int unsigned CW    = COORD_BITS;
  localparam int unsigned SqW   = 2 * CW;
  localparam int unsigned ArgW  = 2 * CW + 1 + 2 * FRAC_BITS;
  localparam int unsigned NIt   = (ArgW + 1) / 2;
  localparam int unsigned RadW  = 2 * NIt;
  localparam int unsigned RemW  = NIt + 3;
  localparam int unsigned ItW   = $clog2(NIt + 1);
  localparam logic [ItW-1:0] LastIt = ItW'(NIt - 1);

  // Coordinates as seen by the datapath.
  logic [CW-1:0] in_x, in_y;

  generate
    if (CW <= InCoordW) begin : g_trunc
      assign in_x = in_item_i.point_x[CW-1:0];
      assign in_y = in_item_i.point_y[CW-1:0];
    end else begin : g_ext
      assign in_x = {{(CW - InCoordW){1'b0}}, in_item_i.point_x};
      assign in_y = {{(CW - InCoordW){1'b0}}, in_item_i.point_y};
    end
  endgenerate

  logic [CW-1:0]     cur_x_q, cur_y_q, prev_x_q, prev_y_q;
  logic              last_q;
  logic [CW-1:0]     ax_q, ay_q;
  logic [SqW-1:0]    sx_q, sy_q;
  logic [RadW-1:0]   rad_q;
  logic [RemW-1:0]   rem_q;
  logic [NIt-1:0]    root_q;
  logic [ItW-1:0]    it_q;
  logic              have_prev_q;
  logic [LengthW-1:0] run_q;
  logic [CountW-1:0] seg_q;
  logic              out_valid_q;
  result_t           out_q;

  // Absolute coordinate differences.
  logic signed [CW:0] dx, dy;
  logic [CW:0]        adx, ady;

  always_comb begin
    dx  = $signed({cur_x_q[CW-1], cur_x_q}) - $signed({prev_x_q[CW-1], prev_x_q});
    dy  = $signed({cur_y_q[CW-1], cur_y_q}) - $signed({prev_y_q[CW-1], prev_y_q});
    adx = dx[CW] ? (CW+1)'(-dx) : dx;
    ady = dy[CW] ? (CW+1)'(-dy) : dy;
  end

  // Scaled radicand: the squared distance shifted by twice the fraction bits.
  logic [ArgW-1:0] arg;
  assign arg = ArgW'({1'b0, sx_q} + {1'b0, sy_q}) << (2 * FRAC_BITS);

  // One restoring square root step on the top bit pair.
  logic [RemW-1:0] rem_sh, trial;
  logic            fits;

  always_comb begin
    rem_sh = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
    trial  = {1'b0, root_q, 2'b01};
    fits   = rem_sh >= trial;
  end

  // Saturating accumulation of the segment length.
  logic [LengthW:0] sum;
  assign sum = {1'b0, run_q} + (LengthW+1)'(root_q);

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cur_x_q <= in_x;
      cur_y_q <= in_y;
      last_q  <= in_item_i.is_last;
      if (!have_prev_q) begin
        prev_x_q <= in_x;
        prev_y_q <= in_y;
      end
    end
    if (cmd_i.diff) begin
      ax_q     <= adx[CW-1:0];
      ay_q     <= ady[CW-1:0];
      prev_x_q <= cur_x_q;
      prev_y_q <= cur_y_q;
    end
    if (cmd_i.square) begin
      sx_q <= ax_q * ax_q;
      sy_q <= ay_q * ay_q;
    end
    if (cmd_i.load) begin
      rad_q  <= RadW'(arg);
      rem_q  <= '0;
      root_q <= '0;
    end else if (cmd_i.step) begin
      rad_q  <= rad_q << 2;
      rem_q  <= fits ? rem_sh - trial : rem_sh;
      root_q <= {root_q[NIt-2:0], fits};
    end
    if (cmd_i.emit) begin
      out_q.path_length   <= run_q;
      out_q.segment_count <= seg_q;
    end
  end

  // Path state, iteration counter and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_prev_q <= 1'b0;
      run_q       <= '0;
      seg_q       <= '0;
      it_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept && !cmd_i.emit) begin
        have_prev_q <= 1'b1;
      end
      if (cmd_i.load) begin
        it_q <= '0;
      end else if (cmd_i.step) begin
        it_q <= it_q + 1'b1;
      end
      if (cmd_i.acc) begin
        run_q <= sum[LengthW] ? LengthMax : sum[LengthW-1:0];
        if (seg_q != CountMax) begin
          seg_q <= seg_q + 1'b1;
        end
      end
      if (cmd_i.emit) begin
        have_prev_q <= 1'b0;
        run_q       <= '0;
        seg_q       <= '0;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    sts_o.have_prev = have_prev_q;
    sts_o.last      = last_q;
    sts_o.in_last   = in_item_i.is_last;
    sts_o.root_done = (it_q == LastIt);
    sts_o.out_free  = !out_valid_q || !out_stall_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // A path is cleared once its result has been taken into the output register.
  a_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (run_q == '0) && (seg_q == '0) && !have_prev_q)
    else $error("path state not cleared after emit");

  // The root never runs past its last bit pair.
  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step |-> it_q <= LastIt)
    else $error("square root stepped past its last bit pair");

  // The segment count holds once saturated.
  a_count_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc && !cmd_i.emit && (seg_q == CountMax) |=> seg_q == CountMax)
    else $error("segment count wrapped");

endmodule

`default_nettype wire

>>> rtl/core/epl_ctrl.sv
// ----------------------------------------------------------------------------
// Euclidean path length: controller
// Sequences each point after the first of its path through difference,
// squaring, square root and accumulation, and hands the total to the output register on the last point.
// ----------------------------------------------------------------------------
`default_nettype none

module epl_ctrl
  import epl_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire ctrl_sts_t sts_i,
  output ctrl_cmd_t      cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (!sts_i.have_prev && sts_i.in_last) begin
          // A first point that is also the last goes straight to the output.
          in_stall_o = !sts_i.out_free;
          if (in_valid_i && sts_i.out_free) begin
            cmd_o.accept = 1'b1;
            cmd_o.emit   = 1'b1;
          end
        end else begin
          in_stall_o = 1'b0;
          if (in_valid_i) begin
            cmd_o.accept = 1'b1;
            if (sts_i.have_prev) begin
              state_d = ST_DIFF;
            end
          end
        end
      end
      ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = ST_SQUARE;
      end
      ST_SQUARE: begin
        cmd_o.square = 1'b1;
        state_d      = ST_LOAD;
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        state_d    = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.step = 1'b1;
        if (sts_i.root_done) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.acc = 1'b1;
        state_d   = sts_i.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/core/euclidean_path_length.sv
// ----------------------------------------------------------------------------
// Euclidean path length: top level
// Streams the points of an open path and returns its fixed-point length
// and segment count when the last point arrives.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake                 Item
//   in        input       in_valid_i / in_stall_o   point_t (x, y, last flag)
//   out       output      out_valid_o / out_stall_i result_t (length, count)
//
// The first point of a path is only accepted; every further point then
// passes through the difference, squaring, load, NIt bit-pair steps of the
// shared square root and accumulation, NIt = (2*COORD_BITS +
// 2*FRAC_BITS + 2) / 2. A later last point then moves the total into the
// output register; a one-point path is moved there in the cycle it is accepted.
// After reset the path is empty and the output register holds nothing.
// The output register lets the next path proceed while a result waits;
// a further last point waits only while that result is still stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module euclidean_path_length
  import epl_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned FRAC_BITS  = 8
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   in_valid_i,
  output logic        in_stall_o,
  input  wire point_t in_item_i,
  output logic        out_valid_o,
  input  wire logic   out_stall_i,
  output result_t     out_item_o
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;
  logic      in_stall_raw;

  // A first point that is also a last point must find the output register free.
  assign in_stall_o = in_stall_raw;

  epl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_raw),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  epl_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_item_i   (in_item_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

>>> tb/euclidean_path_length_test.sv
// ----------------------------------------------------------------------------
// Euclidean path length: self-checking testbench
// Streams paths of signed points into the block under random sender gaps and
// receiver stalls. A predictor sums the exact fixed-point segment lengths and
// the segment counts, and every result item is compared against it in order.
// ----------------------------------------------------------------------------
`default_nettype none

module euclidean_path_length_test;
  import epl_pkg::*;

  localparam int FracBits   = 8;
  localparam int IdleLimit  = 2000;
  localparam int SettleWait = 64;
  localparam int RandPoints = 500;

  // Predicts the total of each path and holds the totals still to arrive.
  class path_length_tracker;
    logic signed [InCoordW-1:0] prev_x;
    logic signed [InCoordW-1:0] prev_y;
    logic                       have_prev;
    logic [LengthW-1:0]         running_length;
    logic [CountW-1:0]          segments_seen;
    result_t                    pending_totals[$];
    int                         mismatches;
    int                         points_seen;
    int                         totals_checked;

    function new();
      mismatches     = 0;
      points_seen    = 0;
      totals_checked = 0;
      clear_path();
    endfunction

    function void clear_path();
      prev_x         = '0;
      prev_y         = '0;
      have_prev      = 1'b0;
      running_length = '0;
      segments_seen  = '0;
    endfunction

    // Exact floor of the segment length scaled by 2^FracBits.
    function logic [LengthW-1:0] segment_len(logic signed [InCoordW-1:0] ax,
                                             logic signed [InCoordW-1:0] ay,
                                             logic signed [InCoordW-1:0] bx,
                                             logic signed [InCoordW-1:0] by);
      int          dx;
      int          dy;
      longint      sq;
      logic [63:0] arg;
      logic [63:0] root;
      logic [63:0] rem;
      logic [63:0] trial;
      dx = int'(bx) - int'(ax);
      dy = int'(by) - int'(ay);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      sq   = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy);
      arg  = 64'(sq) << (2 * FracBits);
      root = '0;
      rem  = '0;
      // Restoring square root, one bit pair at a time from the top.
      for (int k = 31; k >= 0; k--) begin
        rem   = (rem << 2) | 64'(arg[2*k +: 2]);
        trial = (root << 2) | 64'd1;
        if (rem >= trial) begin
          rem  = rem - trial;
          root = (root << 1) | 64'd1;
        end else begin
          root = root << 1;
        end
      end
      return root[LengthW-1:0];
    endfunction

    // Takes one accepted point and queues the total when the path ends.
    function void add_point(point_t p);
      logic [LengthW-1:0] seg;
      logic [LengthW:0]   sum;
      result_t            total;
      points_seen++;
      if (have_prev) begin
        seg = segment_len(prev_x, prev_y, p.point_x, p.point_y);
        sum = {1'b0, running_length} + {1'b0, seg};
        running_length = sum[LengthW] ? LengthMax : sum[LengthW-1:0];
        if (segments_seen != CountMax) segments_seen++;
      end
      prev_x    = p.point_x;
      prev_y    = p.point_y;
      have_prev = 1'b1;
      if (p.is_last) begin
        total.path_length   = running_length;
        total.segment_count = segments_seen;
        pending_totals.push_back(total);
        clear_path();
      end
    endfunction

    // Compares one result item with the oldest expected total.
    function void check_total(result_t got);
      result_t want;
      if (pending_totals.size() == 0) begin
        $error("unexpected result: path_length %0d, segment_count %0d",
               got.path_length, got.segment_count);
        mismatches++;
        return;
      end
      want = pending_totals.pop_front();
      totals_checked++;
      if (got.path_length !== want.path_length) begin
        $error("path_length: expected %0d, actual %0d",
               want.path_length, got.path_length);
        mismatches++;
      end
      if (got.segment_count !== want.segment_count) begin
        $error("segment_count: expected %0d, actual %0d",
               want.segment_count, got.segment_count);
        mismatches++;
      end
    endfunction
  endclass

  logic    clk_i     = 1'b0;
  logic    rst_ni    = 1'b0;
  logic    in_valid  = 1'b0;
  point_t  in_item   = '0;
  logic    out_stall = 1'b0;
  logic    in_stall_o;
  logic    out_valid_o;
  result_t out_item_o;

  path_length_tracker tracker;
  int  burst_left = 0;
  int  idle_count = 0;
  int  stall_left = 0;
  int  stall_mode = 0;
  int  paths_sent = 0;

  euclidean_path_length dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall),
    .out_item_o  (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  // Receiver stall pattern: runs of free flow, random stalls, solid stalls
  // and alternate-cycle stalls.
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(4, 40);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= $urandom_range(0, 1);
      2: out_stall <= 1'b1;
      default: out_stall <= ~out_stall;
    endcase
  end

  // Watches both channels and ends the run if nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_stall_o === 1'b0) tracker.add_point(in_item);
      if (out_valid_o === 1'b1 && !out_stall) tracker.check_total(out_item_o);
      if ((in_valid && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall)) begin
        idle_count = 0;
      end else begin
        idle_count++;
      end
      if (idle_count >= IdleLimit) begin
        $display("timeout: no item moved for %0d cycles", IdleLimit);
        $display("euclidean_path_length_test: errors");
        $finish;
      end
    end
  end

  // Offers one point and waits until the block takes it. The sender works
  // in bursts with random gaps in between.
  task automatic send_point(input int x, input int y, input bit last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) != 0) ? $urandom_range(1, 40) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_item.point_x <= x[InCoordW-1:0];
    in_item.point_y <= y[InCoordW-1:0];
    in_item.is_last <= last;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    if (last) paths_sent++;
  endtask

  // Picks a coordinate: anywhere, near the previous one, at an extreme, at zero or at minus one.
  function automatic int pick_coord(int prev);
    case ($urandom_range(0, 3))
      0: return prev + $urandom_range(0, 30) - 15;
      1: begin
        case ($urandom_range(0, 3))
          0: return -32768;
          1: return 32767;
          2: return 0;
          default: return -1;
        endcase
      end
      default: return int'($signed(16'($urandom)));
    endcase
  endfunction

  initial begin
    int  len;
    int  x;
    int  y;
    int  rand_points;
    tracker = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-point paths, including the coordinate extremes.
    send_point(0, 0, 1'b1);
    send_point(-32768, 32767, 1'b1);
    // A 3-4-5 triangle side and a diagonal with an irrational length.
    send_point(0, 0, 1'b0);
    send_point(3, 4, 1'b1);
    send_point(1, 1, 1'b0);
    send_point(2, 2, 1'b1);
    // The longest possible segment, both ways across the square.
    send_point(-32768, -32768, 1'b0);
    send_point(32767, 32767, 1'b1);
    send_point(32767, -32768, 1'b0);
    send_point(-32768, 32767, 1'b0);
    send_point(32767, 32767, 1'b1);
    // A zero-length segment.
    send_point(100, 100, 1'b0);
    send_point(100, 100, 1'b1);
    // Segments along each axis.
    send_point(-32768, 0, 1'b0);
    send_point(32767, 0, 1'b0);
    send_point(32767, -32768, 1'b0);
    send_point(0, 0, 1'b1);

    // Random paths, mostly short, now and then a single point or a long run.
    rand_points = 0;
    x = 0;
    y = 0;
    while (rand_points < RandPoints) begin
      case ($urandom_range(0, 9))
        0: len = 1;
        8: len = $urandom_range(9, 30);
        default: len = $urandom_range(2, 8);
      endcase
      for (int i = 0; i < len; i++) begin
        x = pick_coord(x);
        y = pick_coord(y);
        send_point(x, y, i == len - 1);
        rand_points++;
      end
    end
    in_valid <= 1'b0;

    // Let the monitor take the final point, drain the outstanding totals,
    // then give the block time to misbehave.
    @(posedge clk_i);
    while (tracker.pending_totals.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);

    $display("Sent %0d points in %0d paths and compared %0d totals,",
             tracker.points_seen, paths_sent, tracker.totals_checked);
    $display("among them single-point paths and extreme and zero-length segments.");
    if (tracker.mismatches == 0) begin
      $display("euclidean_path_length_test: clean");
    end else begin
      $display("euclidean_path_length_test: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
